@@ rtl/ltsp_pkg.sv @@
// Shared types and constants for the legacy transaction stream parser.
// Used by rtl/legacy_tx_stream_parser.sv; depends on nothing else.
`default_nettype none

package ltsp_pkg;

   localparam int COUNT_BITS = 20;
   localparam int ELEM_W     = 20;
   localparam int LIMIT_W    = 20;
   localparam int VALUE_W    = 64;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000);

   localparam logic [7:0] PREFIX_16 = 8'hfd;
   localparam logic [7:0] PREFIX_32 = 8'hfe;

   localparam logic [1:0] FORM_NONE = 2'd0;
   localparam logic [1:0] FORM_16   = 2'd1;
   localparam logic [1:0] FORM_32   = 2'd2;
   localparam logic [1:0] FORM_64   = 2'd3;

   typedef enum logic [3:0] {
      KIND_VERSION   = 4'd0,
      KIND_IN_COUNT  = 4'd1,
      KIND_TXID      = 4'd2,
      KIND_INDEX     = 4'd3,
      KIND_SIG_LEN   = 4'd4,
      KIND_SIG_BYTE  = 4'd5,
      KIND_SEQ       = 4'd6,
      KIND_OUT_COUNT = 4'd7,
      KIND_VALUE     = 4'd8,
      KIND_SPK_LEN   = 4'd9,
      KIND_SPK_BYTE  = 4'd10,
      KIND_LOCKTIME  = 4'd11,
      KIND_IGNORED   = 4'd12
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_ZERO_IN    = 3'd1,
      STAT_IN_BIG     = 3'd2,
      STAT_OUT_BIG    = 3'd3,
      STAT_TRUNCATED  = 3'd4,
      STAT_TRAILING   = 3'd5
   } status_type;

   typedef struct packed {
      kind_type           field_kind;
      logic [ELEM_W-1:0]  element_number;
      logic [7:0]         byte_echo;
      logic               field_complete;
      logic [VALUE_W-1:0] field_value;
      logic               tx_done;
      status_type         parse_status;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/legacy_tx_stream_parser.sv @@
// Top level of the legacy transaction stream parser: field walker and output buffer.
// Depends on rtl/ltsp_pkg.sv.
`default_nettype none

// The parser takes one transaction byte per beat and returns one registered tagged beat
// per byte. A new byte can be accepted in every cycle while req_stall is low; the field
// state updates in a single pass per byte. A two-entry output buffer (output register
// plus skid register) lets one more byte be accepted while a result is stalled; req_stall
// rises only once both entries are full. The user must write the count limit through
// csr_wr_en and csr_count_limit only while the parser is idle; the block does not enforce it.
module legacy_tx_stream_parser
   import ltsp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last_byte,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [3:0]         rsp_field_kind,
   output      logic [ELEM_W-1:0]  rsp_element_number,
   output      logic [7:0]         rsp_byte_echo,
   output      logic               rsp_field_complete,
   output      logic [VALUE_W-1:0] rsp_field_value,
   output      logic               rsp_tx_done,
   output      logic [2:0]         rsp_parse_status,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_count_limit
);

   logic [LIMIT_W-1:0]    limit_ff;
   kind_type              phase_ff,  phase_in;
   logic [3:0]            bif_ff,    bif_in;
   logic [1:0]            form_ff,   form_in;
   logic [VALUE_W-1:0]    acc_ff,    acc_in;
   logic [VALUE_W-1:0]    sbl_ff,    sbl_in;
   logic [COUNT_BITS-1:0] left_ff,   left_in;
   logic [COUNT_BITS-1:0] cnt_ff,    cnt_in;
   status_type            err_ff,    err_in;

   rsp_type               out_ff,    skid_ff,   beat_in;
   logic                  out_valid_ff, skid_valid_ff;
   logic                  accept, pop;

   function automatic logic too_big(input logic [VALUE_W-1:0] v,
                                    input logic [LIMIT_W-1:0] lim);
      logic over_mask;
      over_mask = (v >> COUNT_BITS) != '0;
      return over_mask || (v > VALUE_W'(lim));
   endfunction

   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_comb begin
      logic [3:0]         fx_need;
      logic [VALUE_W-1:0] fx_acc;
      logic [3:0]         fx_bif;
      logic               fx_done;
      logic [1:0]         cp_form;
      logic [3:0]         cp_bif;
      logic [VALUE_W-1:0] cp_acc;
      logic               cp_done;
      logic [VALUE_W-1:0] cp_val;
      logic               done;
      logic [VALUE_W-1:0] val;
      logic [COUNT_BITS-1:0] left_dec;
      logic [COUNT_BITS-1:0] cnt_inc;
      logic [VALUE_W-1:0] part;
      status_type         status;
      logic               elem_phase;

      phase_in = phase_ff;
      bif_in   = bif_ff;
      form_in  = form_ff;
      acc_in   = acc_ff;
      sbl_in   = sbl_ff;
      left_in  = left_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      done     = 1'b0;
      val      = '0;
      part     = '0;
      left_dec = left_ff - 1'b1;
      cnt_inc  = cnt_ff + 1'b1;

      case (phase_ff)
         KIND_VALUE: fx_need = 4'd8;
         KIND_IN_COUNT, KIND_SIG_LEN, KIND_OUT_COUNT, KIND_SPK_LEN: begin
            case (form_ff)
               FORM_16: fx_need = 4'd2;
               FORM_32: fx_need = 4'd4;
               default: fx_need = 4'd8;
            endcase
         end
         default: fx_need = 4'd4;
      endcase

      fx_acc  = acc_ff | (VALUE_W'(req_data_byte) << {bif_ff[2:0], 3'b000});
      fx_bif  = bif_ff + 1'b1;
      fx_done = fx_bif >= fx_need;

      cp_form = form_ff;
      cp_bif  = bif_ff;
      cp_acc  = acc_ff;
      cp_done = 1'b0;
      cp_val  = '0;
      if (form_ff == FORM_NONE) begin
         if (req_data_byte < PREFIX_16) begin
            cp_done = 1'b1;
            cp_val  = VALUE_W'(req_data_byte);
         end else begin
            cp_form = (req_data_byte == PREFIX_16) ? FORM_16 :
                      (req_data_byte == PREFIX_32) ? FORM_32 : FORM_64;
            cp_bif  = '0;
            cp_acc  = '0;
         end
      end else if (fx_done) begin
         cp_done = 1'b1;
         cp_val  = fx_acc;
         cp_acc  = '0;
         cp_bif  = '0;
         cp_form = FORM_NONE;
      end else begin
         cp_acc = fx_acc;
         cp_bif = fx_bif;
      end

      unique case (phase_ff)
         KIND_VERSION, KIND_INDEX, KIND_SEQ, KIND_VALUE, KIND_LOCKTIME: begin
            if (fx_done) begin
               done   = 1'b1;
               val    = fx_acc;
               acc_in = '0;
               bif_in = '0;
               unique case (phase_ff)
                  KIND_VERSION: phase_in = KIND_IN_COUNT;
                  KIND_INDEX:   phase_in = KIND_SIG_LEN;
                  KIND_VALUE:   phase_in = KIND_SPK_LEN;
                  KIND_LOCKTIME: phase_in = KIND_IGNORED;
                  default: begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        phase_in = KIND_OUT_COUNT;
                        cnt_in   = '0;
                     end else begin
                        phase_in = KIND_TXID;
                        cnt_in   = cnt_inc;
                        sbl_in   = VALUE_W'(32);
                     end
                  end
               endcase
            end else begin
               acc_in = fx_acc;
               bif_in = fx_bif;
            end
         end
         KIND_IN_COUNT, KIND_SIG_LEN, KIND_OUT_COUNT, KIND_SPK_LEN: begin
            form_in = cp_form;
            bif_in  = cp_bif;
            acc_in  = cp_acc;
            done    = cp_done;
            val     = cp_val;
            if (cp_done) begin
               unique case (phase_ff)
                  KIND_IN_COUNT: begin
                     if (cp_val == '0) begin
                        err_in   = STAT_ZERO_IN;
                        phase_in = KIND_IGNORED;
                     end else if (too_big(cp_val, limit_ff)) begin
                        err_in   = STAT_IN_BIG;
                        phase_in = KIND_IGNORED;
                     end else begin
                        left_in  = COUNT_BITS'(cp_val);
                        cnt_in   = '0;
                        phase_in = KIND_TXID;
                        sbl_in   = VALUE_W'(32);
                     end
                  end
                  KIND_SIG_LEN: begin
                     if (cp_val == '0) begin
                        phase_in = KIND_SEQ;
                     end else begin
                        sbl_in   = cp_val;
                        phase_in = KIND_SIG_BYTE;
                     end
                  end
                  KIND_OUT_COUNT: begin
                     if (too_big(cp_val, limit_ff)) begin
                        err_in   = STAT_OUT_BIG;
                        phase_in = KIND_IGNORED;
                     end else if (cp_val == '0) begin
                        phase_in = KIND_LOCKTIME;
                     end else begin
                        left_in  = COUNT_BITS'(cp_val);
                        cnt_in   = '0;
                        phase_in = KIND_VALUE;
                     end
                  end
                  default: begin
                     if (cp_val == '0) begin
                        left_in = left_dec;
                        if (left_dec == '0) begin
                           phase_in = KIND_LOCKTIME;
                           cnt_in   = '0;
                        end else begin
                           phase_in = KIND_VALUE;
                           cnt_in   = cnt_inc;
                        end
                     end else begin
                        sbl_in   = cp_val;
                        phase_in = KIND_SPK_BYTE;
                     end
                  end
               endcase
            end
         end
         KIND_TXID, KIND_SIG_BYTE, KIND_SPK_BYTE: begin
            sbl_in = sbl_ff - 1'b1;
            if (sbl_in == '0) begin
               unique case (phase_ff)
                  KIND_TXID:     phase_in = KIND_INDEX;
                  KIND_SIG_BYTE: phase_in = KIND_SEQ;
                  default: begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        phase_in = KIND_LOCKTIME;
                        cnt_in   = '0;
                     end else begin
                        phase_in = KIND_VALUE;
                        cnt_in   = cnt_inc;
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = KIND_IGNORED;
            if (err_ff == STAT_OK) begin
               err_in = STAT_TRAILING;
            end
         end
      endcase

      if (err_in != STAT_OK) begin
         status = err_in;
      end else if (phase_in == KIND_IGNORED) begin
         status = STAT_OK;
      end else if (phase_in == KIND_VERSION || phase_in == KIND_IN_COUNT) begin
         part = (phase_in == KIND_IN_COUNT && form_in != FORM_NONE) ? acc_in : '0;
         if (part == '0) begin
            status = STAT_ZERO_IN;
         end else if (too_big(part, limit_ff)) begin
            status = STAT_IN_BIG;
         end else begin
            status = STAT_TRUNCATED;
         end
      end else if (phase_in == KIND_OUT_COUNT) begin
         part   = (form_in != FORM_NONE) ? acc_in : '0;
         status = too_big(part, limit_ff) ? STAT_OUT_BIG : STAT_TRUNCATED;
      end else begin
         status = STAT_TRUNCATED;
      end
      if (!req_last_byte) begin
         status = err_in;
      end

      elem_phase = (phase_ff >= KIND_TXID && phase_ff <= KIND_SEQ) ||
                   (phase_ff >= KIND_VALUE && phase_ff <= KIND_SPK_BYTE);

      beat_in.field_kind     = (phase_ff > KIND_IGNORED) ? KIND_IGNORED : phase_ff;
      beat_in.element_number = elem_phase ? ELEM_W'(cnt_ff) : '0;
      beat_in.byte_echo      = req_data_byte;
      beat_in.field_complete = done;
      beat_in.field_value    = val;
      beat_in.tx_done        = req_last_byte;
      beat_in.parse_status   = status;

      if (req_last_byte) begin
         phase_in = KIND_VERSION;
         bif_in   = '0;
         form_in  = FORM_NONE;
         acc_in   = '0;
         sbl_in   = '0;
         left_in  = '0;
         cnt_in   = '0;
         err_in   = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         phase_ff      <= KIND_VERSION;
         bif_ff        <= '0;
         form_ff       <= FORM_NONE;
         acc_ff        <= '0;
         sbl_ff        <= '0;
         left_ff       <= '0;
         cnt_ff        <= '0;
         err_ff        <= STAT_OK;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_count_limit;
         end
         if (accept) begin
            phase_ff <= phase_in;
            bif_ff   <= bif_in;
            form_ff  <= form_in;
            acc_ff   <= acc_in;
            sbl_ff   <= sbl_in;
            left_ff  <= left_in;
            cnt_ff   <= cnt_in;
            err_ff   <= err_in;
         end
         if (skid_valid_ff) begin
            if (pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || pop) begin
               out_ff       <= beat_in;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= beat_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_field_kind     = out_ff.field_kind;
   assign rsp_element_number = out_ff.element_number;
   assign rsp_byte_echo      = out_ff.byte_echo;
   assign rsp_field_complete = out_ff.field_complete;
   assign rsp_field_value    = out_ff.field_value;
   assign rsp_tx_done        = out_ff.tx_done;
   assign rsp_parse_status   = out_ff.parse_status;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> (phase_ff == KIND_VERSION && err_ff == STAT_OK))
      else $error("parser did not restart after the final byte");

   a_error_parks: assert property (@(posedge clock) disable iff (reset)
      (err_ff != STAT_OK) |-> (phase_ff == KIND_IGNORED))
      else $error("error set while still walking fields");

   a_elements_pending: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff >= KIND_TXID && phase_ff <= KIND_SEQ) ||
       (phase_ff >= KIND_VALUE && phase_ff <= KIND_SPK_BYTE)) |-> (left_ff != '0))
      else $error("element phase with no elements left");

   a_value_only_when_complete: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.field_complete) |-> (out_ff.field_value == '0))
      else $error("field value shown on an incomplete field");

endmodule

`default_nettype wire

@@ tb/legacy_tx_stream_parser_tb.sv @@
// Self-checking testbench for legacy_tx_stream_parser: streams whole, cut and broken transactions
// through the block and checks every result beat against a behavioral parser kept in the bench.
// Depends on rtl/ltsp_pkg.sv and rtl/legacy_tx_stream_parser.sv.
`timescale 1ns / 100ps

module legacy_tx_stream_parser_tb;
   import ltsp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] PREFIX_64 = 8'hff;
   localparam logic [63:0] COUNT_MASK = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_MIN = LIMIT_W'(1);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(1000000);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   typedef enum int {
      TX_GOOD, TX_CUT, TX_TRAILING, TX_ZERO_IN, TX_BIG_IN, TX_BIG_OUT, TX_HUGE_SCRIPT
   } tx_shape_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'd0;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_field_kind;
   logic [ELEM_W-1:0]  rsp_element_number;
   logic [7:0]         rsp_byte_echo;
   logic               rsp_field_complete;
   logic [VALUE_W-1:0] rsp_field_value;
   logic               rsp_tx_done;
   logic [2:0]         rsp_parse_status;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_count_limit = '0;

   legacy_tx_stream_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_field_kind     (rsp_field_kind),
      .rsp_element_number (rsp_element_number),
      .rsp_byte_echo      (rsp_byte_echo),
      .rsp_field_complete (rsp_field_complete),
      .rsp_field_value    (rsp_field_value),
      .rsp_tx_done        (rsp_tx_done),
      .rsp_parse_status   (rsp_parse_status),
      .csr_wr_en          (csr_wr_en),
      .csr_count_limit    (csr_count_limit)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Parser state kept by the bench.
   logic [LIMIT_W-1:0] cp_limit = LIMIT_RESET;
   kind_type           cp_phase = KIND_VERSION;
   logic [3:0]         cp_idx = '0;
   logic [1:0]         cp_form = FORM_NONE;
   logic [63:0]        cp_acc = '0;
   logic [63:0]        cp_script = '0;
   logic [ELEM_W-1:0]  cp_left = '0;
   logic [ELEM_W-1:0]  cp_ctr = '0;
   status_type         cp_err = STAT_OK;

   byte_beat_type pending_beats[$];
   rsp_type    expected_beats[$];
   logic [7:0] tx_bytes[$];
   int         predicted_count = 0;
   int         checked_count = 0;
   int         mismatches = 0;
   int         cycle_count = 0;
   logic       hold_input = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int         stall_span = 0;
   logic [7:0] stall_ctr = '0;

   function automatic void clear_parser();
      cp_phase = KIND_VERSION;
      cp_idx = '0;
      cp_form = FORM_NONE;
      cp_acc = '0;
      cp_script = '0;
      cp_left = '0;
      cp_ctr = '0;
      cp_err = STAT_OK;
   endfunction

   function automatic logic count_too_big(input logic [63:0] v);
      return (v > 64'(cp_limit)) || (v > COUNT_MASK);
   endfunction

   function automatic logic take_fixed(input logic [7:0] b, input int nbytes,
                                       output logic [63:0] val);
      cp_acc = cp_acc | (64'(b) << (8 * cp_idx[2:0]));
      cp_idx = cp_idx + 4'd1;
      if (int'(cp_idx) >= nbytes) begin
         val = cp_acc;
         cp_acc = '0;
         cp_idx = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic take_compact(input logic [7:0] b, output logic [63:0] val);
      int need;
      if (cp_form == FORM_NONE) begin
         if (b < PREFIX_16) begin
            val = 64'(b);
            return 1'b1;
         end
         cp_form = (b == PREFIX_16) ? FORM_16 : (b == PREFIX_32) ? FORM_32 : FORM_64;
         cp_idx = '0;
         cp_acc = '0;
         return 1'b0;
      end
      need = (cp_form == FORM_16) ? 2 : (cp_form == FORM_32) ? 4 : 8;
      if (take_fixed(b, need, val)) begin
         cp_form = FORM_NONE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void advance_element(input logic is_input);
      cp_left = cp_left - 1'b1;
      cp_ctr = cp_ctr + 1'b1;
      if (cp_left == '0) begin
         cp_phase = is_input ? KIND_OUT_COUNT : KIND_LOCKTIME;
         cp_ctr = '0;
      end else begin
         cp_phase = is_input ? KIND_TXID : KIND_VALUE;
         if (is_input) cp_script = 64'd32;
      end
   endfunction

   function automatic status_type end_status();
      logic [63:0] v;
      if (cp_err != STAT_OK) return cp_err;
      if (cp_phase == KIND_IGNORED) return STAT_OK;
      if (cp_phase <= KIND_IN_COUNT) begin
         v = (cp_phase == KIND_IN_COUNT && cp_form != FORM_NONE) ? cp_acc : '0;
         if (v == '0) return STAT_ZERO_IN;
         if (count_too_big(v)) return STAT_IN_BIG;
         return STAT_TRUNCATED;
      end
      if (cp_phase == KIND_OUT_COUNT) begin
         v = (cp_form != FORM_NONE) ? cp_acc : '0;
         if (count_too_big(v)) return STAT_OUT_BIG;
      end
      return STAT_TRUNCATED;
   endfunction

   function automatic rsp_type parse_byte(input logic [7:0] b, input logic last);
      rsp_type     r;
      logic        done;
      logic [63:0] val;
      kind_type    kind;
      done = 1'b0;
      val = '0;
      kind = cp_phase;
      r.element_number = '0;
      if ((cp_phase >= KIND_TXID && cp_phase <= KIND_SEQ) ||
          (cp_phase >= KIND_VALUE && cp_phase <= KIND_SPK_BYTE))
         r.element_number = cp_ctr;
      case (cp_phase)
         KIND_VERSION: begin
            done = take_fixed(b, 4, val);
            if (done) cp_phase = KIND_IN_COUNT;
         end
         KIND_IN_COUNT: begin
            done = take_compact(b, val);
            if (done) begin
               if (val == '0) begin
                  cp_err = STAT_ZERO_IN;
                  cp_phase = KIND_IGNORED;
               end else if (count_too_big(val)) begin
                  cp_err = STAT_IN_BIG;
                  cp_phase = KIND_IGNORED;
               end else begin
                  cp_left = val[ELEM_W-1:0];
                  cp_ctr = '0;
                  cp_phase = KIND_TXID;
                  cp_script = 64'd32;
               end
            end
         end
         KIND_TXID: begin
            cp_script = cp_script - 64'd1;
            if (cp_script == '0) cp_phase = KIND_INDEX;
         end
         KIND_INDEX: begin
            done = take_fixed(b, 4, val);
            if (done) cp_phase = KIND_SIG_LEN;
         end
         KIND_SIG_LEN: begin
            done = take_compact(b, val);
            if (done) begin
               if (val == '0) cp_phase = KIND_SEQ;
               else begin
                  cp_script = val;
                  cp_phase = KIND_SIG_BYTE;
               end
            end
         end
         KIND_SIG_BYTE: begin
            cp_script = cp_script - 64'd1;
            if (cp_script == '0) cp_phase = KIND_SEQ;
         end
         KIND_SEQ: begin
            done = take_fixed(b, 4, val);
            if (done) advance_element(1'b1);
         end
         KIND_OUT_COUNT: begin
            done = take_compact(b, val);
            if (done) begin
               if (count_too_big(val)) begin
                  cp_err = STAT_OUT_BIG;
                  cp_phase = KIND_IGNORED;
               end else if (val == '0) cp_phase = KIND_LOCKTIME;
               else begin
                  cp_left = val[ELEM_W-1:0];
                  cp_ctr = '0;
                  cp_phase = KIND_VALUE;
               end
            end
         end
         KIND_VALUE: begin
            done = take_fixed(b, 8, val);
            if (done) cp_phase = KIND_SPK_LEN;
         end
         KIND_SPK_LEN: begin
            done = take_compact(b, val);
            if (done) begin
               if (val == '0) advance_element(1'b0);
               else begin
                  cp_script = val;
                  cp_phase = KIND_SPK_BYTE;
               end
            end
         end
         KIND_SPK_BYTE: begin
            cp_script = cp_script - 64'd1;
            if (cp_script == '0) advance_element(1'b0);
         end
         KIND_LOCKTIME: begin
            done = take_fixed(b, 4, val);
            if (done) cp_phase = KIND_IGNORED;
         end
         default: begin
            kind = KIND_IGNORED;
            if (cp_err == STAT_OK) cp_err = STAT_TRAILING;
            cp_phase = KIND_IGNORED;
         end
      endcase
      if (!done) val = '0;
      r.field_kind = kind;
      r.byte_echo = b;
      r.field_complete = done;
      r.field_value = val;
      r.tx_done = last;
      r.parse_status = last ? end_status() : cp_err;
      if (last) clear_parser();
      return r;
   endfunction

   // Transaction builder.
   function automatic void add_tx_byte(input logic [7:0] b);
      tx_bytes.insert(tx_bytes.size(), b);
   endfunction

   function automatic void put_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) add_tx_byte(v[8*i +: 8]);
   endfunction

   function automatic void put_random(input int n);
      for (int i = 0; i < n; i++) add_tx_byte(8'($urandom));
   endfunction

   function automatic logic [1:0] pick_form(input logic [63:0] v);
      logic [1:0] lo;
      lo = (v < 64'hfd) ? FORM_NONE : (v <= 64'hffff) ? FORM_16 :
           (v <= 64'hffff_ffff) ? FORM_32 : FORM_64;
      if ($urandom_range(0, 3) == 0) return 2'($urandom_range(int'(lo), 3));
      return lo;
   endfunction

   function automatic void put_compact(input logic [63:0] v, input logic [1:0] form);
      case (form)
         FORM_NONE: add_tx_byte(v[7:0]);
         FORM_16: begin
            add_tx_byte(PREFIX_16);
            put_le(v, 2);
         end
         FORM_32: begin
            add_tx_byte(PREFIX_32);
            put_le(v, 4);
         end
         default: begin
            add_tx_byte(PREFIX_64);
            put_le(v, 8);
         end
      endcase
   endfunction

   function automatic logic [63:0] big_count();
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom} | (COUNT_MASK + 64'd1);
      return 64'(cp_limit) + 64'($urandom_range(1, 40));
   endfunction

   function automatic void build_tx(input tx_shape_type shape);
      logic [63:0] n_in;
      logic [63:0] n_out;
      logic [63:0] slen;
      int          max_el;
      tx_bytes.delete();
      max_el = (cp_limit < 3) ? int'(cp_limit) : 3;
      put_random(4);
      n_in = (shape == TX_ZERO_IN) ? 64'd0 :
             (shape == TX_BIG_IN) ? big_count() : 64'($urandom_range(1, max_el));
      put_compact(n_in, pick_form(n_in));
      if (shape == TX_ZERO_IN || shape == TX_BIG_IN) begin
         put_random($urandom_range(0, 3));
         return;
      end
      for (int i = 0; i < int'(n_in); i++) begin
         put_random(36);
         if (shape == TX_HUGE_SCRIPT) begin
            put_compact({$urandom, $urandom} | 64'h8000_0000_0000_0000, FORM_64);
            put_random($urandom_range(0, 8));
            return;
         end
         slen = 64'($urandom_range(0, 6));
         put_compact(slen, pick_form(slen));
         put_random(int'(slen));
         put_random(4);
      end
      n_out = (shape == TX_BIG_OUT) ? big_count() : 64'($urandom_range(0, max_el));
      put_compact(n_out, pick_form(n_out));
      if (shape == TX_BIG_OUT) begin
         put_random($urandom_range(0, 3));
         return;
      end
      for (int i = 0; i < int'(n_out); i++) begin
         put_random(8);
         slen = 64'($urandom_range(0, 6));
         put_compact(slen, pick_form(slen));
         put_random(int'(slen));
      end
      put_random(4);
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic last);
      byte_beat_type beat;
      beat.data = b;
      beat.last = last;
      pending_beats.insert(pending_beats.size(), beat);
   endfunction

   function automatic tx_shape_type pick_shape();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return TX_GOOD;
      if (r < 60) return TX_CUT;
      if (r < 70) return TX_TRAILING;
      if (r < 77) return TX_ZERO_IN;
      if (r < 84) return TX_BIG_IN;
      if (r < 92) return TX_BIG_OUT;
      return TX_HUGE_SCRIPT;
   endfunction

   function automatic void queue_random_txs(input int target);
      int           queued;
      int           cut;
      tx_shape_type shape;
      queued = 0;
      while (queued < target) begin
         shape = pick_shape();
         build_tx(shape);
         if (shape == TX_TRAILING) put_random($urandom_range(1, 3));
         cut = tx_bytes.size();
         if (shape == TX_CUT) cut = $urandom_range(1, tx_bytes.size() - 1);
         for (int i = 0; i < cut; i++) queue_byte(tx_bytes[i], i == cut - 1);
         queued += cut;
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || checked_count != predicted_count);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_count_limit <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cp_limit = v;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sender: bursts of beats with random gaps; a stalled beat is held unchanged.
   always @(posedge clock) begin
      byte_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_beats.insert(expected_beats.size(),
                                  parse_byte(req_data_byte, req_last_byte));
            predicted_count <= predicted_count + 1;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (!hold_input && pending_beats.size() != 0) begin
            beat = pending_beats.pop_front();
            req_data_byte <= beat.data;
            req_last_byte <= beat.last;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 16);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(8, 120);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_ctr <= stall_ctr + 8'd1;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= stall_ctr[2];
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (checked_count >= predicted_count) begin
            $display("%0t: result beat with no expectation, expected none, actual kind %0d",
                     $time, rsp_field_kind);
            mismatches++;
         end else begin
            want = expected_beats[checked_count];
            check_field("field_kind", 64'(want.field_kind), 64'(rsp_field_kind));
            check_field("element_number", 64'(want.element_number), 64'(rsp_element_number));
            check_field("byte_echo", 64'(want.byte_echo), 64'(rsp_byte_echo));
            check_field("field_complete", 64'(want.field_complete), 64'(rsp_field_complete));
            check_field("field_value", want.field_value, rsp_field_value);
            check_field("tx_done", 64'(want.tx_done), 64'(rsp_tx_done));
            check_field("parse_status", 64'(want.parse_status), 64'(rsp_parse_status));
            checked_count <= checked_count + 1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout", $time);
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Lone final byte in the version field.
      queue_byte(8'hff, 1'b1);
      // Zero input count followed by an ignored byte.
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h55, 1'b1);
      // Input count in the 8-byte form with every bit set.
      for (int i = 0; i < 4; i++) queue_byte(8'hff, 1'b0);
      queue_byte(PREFIX_64, 1'b0);
      for (int i = 0; i < 8; i++) queue_byte(8'hff, i == 7);
      // Input count cut off inside its 2-byte extension.
      for (int i = 0; i < 4; i++) queue_byte(8'h00, 1'b0);
      queue_byte(PREFIX_16, 1'b0);
      queue_byte(8'h7f, 1'b1);
      queue_random_txs(200);
      wait_idle();

      write_limit(LIMIT_MIN);
      queue_random_txs(230);
      wait_idle();

      write_limit(LIMIT_MAX);
      queue_random_txs(230);
      while (pending_beats.size() > 110) @(negedge clock);
      hold_input = 1'b1;
      while (req_valid || checked_count != predicted_count) @(negedge clock);
      hold_input = 1'b0;
      wait_idle();

      write_limit(LIMIT_W'(2));
      queue_random_txs(230);
      wait_idle();

      write_limit(LIMIT_W'($urandom_range(1, 1000000)));
      queue_random_txs(230);
      wait_idle();

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ legacy_tx_stream_parser.f @@
rtl/ltsp_pkg.sv
rtl/legacy_tx_stream_parser.sv
tb/legacy_tx_stream_parser_tb.sv
